// File: src/cbpb_pkg.sv
// Package for the color burn pixel blend: payload word types, fixed-point
// constants and the rounded divide-by-one helper. No dependencies.
`default_nettype none

package cbpb_pkg;

   localparam logic [15:0] ONE_FX  = 16'hFFFF;
   localparam logic [15:0] ZERO_FX = 16'h0000;
   localparam logic [31:0] HALF_FX = 32'd32767;

   localparam int unsigned DIV_QBITS = 17;
   localparam int unsigned DIV_NBITS = 34;
   localparam int unsigned DIV_DBITS = 17;
   // setup register plus one register per quotient bit
   localparam int unsigned DIV_LAT   = DIV_QBITS + 1;

   typedef enum logic [0:0] {
      CSR_OPACITY     = 1'b0,
      CSR_MASK_ENABLE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] base_red;
      logic [15:0] base_green;
      logic [15:0] base_blue;
      logic [15:0] base_alpha;
      logic [15:0] layer_red;
      logic [15:0] layer_green;
      logic [15:0] layer_blue;
      logic [15:0] layer_alpha;
      logic [15:0] mask_value;
      logic        last_pixel;
   } req_type;

   typedef struct packed {
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
      logic [15:0] out_alpha;
      logic        out_last;
   } rsp_type;

   // round(x / 65535), halves up; x must not exceed 65535 * 65535
   function automatic logic [15:0] rnd_div_one(input logic [31:0] x);
      logic [33:0] y;
      logic [33:0] t;
      y = {2'b00, x} + {2'b00, HALF_FX};
      t = y + (y >> 16) + 34'd1;
      return t[31:16];
   endfunction

endpackage

`default_nettype wire

// File: src/cbpb_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating at
// 65535. Depends on cbpb_pkg for the width constants and the saturation value.
`default_nettype none

module cbpb_div (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic [cbpb_pkg::DIV_NBITS-1:0]   num,
   input  wire logic [cbpb_pkg::DIV_DBITS-1:0]   den,
   output logic      [15:0]                      quo
);

   localparam int unsigned QB = cbpb_pkg::DIV_QBITS;
   localparam int unsigned NB = cbpb_pkg::DIV_NBITS;
   localparam int unsigned DB = cbpb_pkg::DIV_DBITS;

   logic [NB-1:0] rem_ff [0:QB];
   logic [DB-1:0] den_ff [0:QB];
   logic [QB-1:0] quo_ff [0:QB];
   logic          ovf_ff [0:QB];

   logic [NB-1:0] den_top;
   assign den_top = {{(NB-DB){1'b0}}, den} << QB;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= (num >= den_top);
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      localparam int unsigned BITPOS = QB - k;
      logic [NB-1:0] sub_in;
      logic          take_in;
      assign sub_in  = {{(NB-DB){1'b0}}, den_ff[k-1]} << BITPOS;
      assign take_in = (rem_ff[k-1] >= sub_in);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take_in ? (rem_ff[k-1] - sub_in) : rem_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | ({{(QB-1){1'b0}}, take_in} << BITPOS);
         end
      end
   end

   // saturate at one
   assign quo = (ovf_ff[QB] || (quo_ff[QB] >= {1'b0, cbpb_pkg::ONE_FX}))
                ? cbpb_pkg::ONE_FX : quo_ff[QB][15:0];

endmodule

`default_nettype wire

// File: src/color_burn_pixel_blend.sv
// Color burn blend of an RGBA layer onto an RGBA base, one pixel word per cycle while not stalled.
// Depends on cbpb_pkg and the pipelined divider cbpb_div.
//
// Usage:
//   req_* carries one pixel word (base, layer, mask, last flag); rsp_* returns
//   the blended word. A word moves when valid is high and stall is low.
//   csr_* writes opacity (index 0) and mask enable (index 1); write only while
//   the pipeline is empty.
// Throughput: one word per cycle while the output is not stalled; the pipeline is 29 register stages, of which
// 18 belong to the ratio and burn dividers (one setup stage plus 17 per-bit stages).
// Stall: while the output word is stalled the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
// Reset: clears all valid bits, opacity to full, mask enable off.
`default_nettype none

module color_burn_pixel_blend (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire cbpb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cbpb_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [0:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   localparam int unsigned PRE_STG = 7;
   localparam int unsigned DLAT    = cbpb_pkg::DIV_LAT;
   localparam int unsigned NSTG    = PRE_STG + DLAT + 4;
   localparam int unsigned NB      = cbpb_pkg::DIV_NBITS;

   typedef struct packed {
      cbpb_pkg::req_type pix;
      logic              copy;
   } side_type;

   logic [15:0] opacity_ff;
   logic        mask_en_ff;
   logic [NSTG-1:0] vld_ff;
   logic en;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= cbpb_pkg::ONE_FX;
         mask_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (cbpb_pkg::csr_index_type'(csr_index))
            cbpb_pkg::CSR_OPACITY:     opacity_ff <= csr_wdata;
            cbpb_pkg::CSR_MASK_ENABLE: mask_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // advance unless the output word is stalled
   assign en        = !vld_ff[NSTG-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // compositing alpha and new alpha
   cbpb_pkg::req_type s1_pix_ff, s2_pix_ff, s3_pix_ff, s4_pix_ff;
   cbpb_pkg::req_type s5_pix_ff, s6_pix_ff, s7_pix_ff;
   logic [15:0] s1_amin_ff, s3_ca_ff, s4_ca_ff, s5_ca_ff, s6_ca_ff, s7_ca_ff, s7_na_ff;
   logic [31:0] s2_prod_ff, s4_prod_ff, s6_prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pix_ff  <= req_data;
         s1_amin_ff <= (req_data.base_alpha < req_data.layer_alpha) ?
                       req_data.base_alpha : req_data.layer_alpha;
         s2_pix_ff  <= s1_pix_ff;
         s2_prod_ff <= s1_amin_ff * opacity_ff;
         s3_pix_ff  <= s2_pix_ff;
         s3_ca_ff   <= cbpb_pkg::rnd_div_one(s2_prod_ff);
         s4_pix_ff  <= s3_pix_ff;
         s4_ca_ff   <= s3_ca_ff;
         s4_prod_ff <= s3_ca_ff * s3_pix_ff.mask_value;
         s5_pix_ff  <= s4_pix_ff;
         s5_ca_ff   <= mask_en_ff ? cbpb_pkg::rnd_div_one(s4_prod_ff) : s4_ca_ff;
         s6_pix_ff  <= s5_pix_ff;
         s6_ca_ff   <= s5_ca_ff;
         s6_prod_ff <= {16'h0000, ~s5_pix_ff.base_alpha} * s5_ca_ff;
         s7_pix_ff  <= s6_pix_ff;
         s7_ca_ff   <= s6_ca_ff;
         s7_na_ff   <= s6_pix_ff.base_alpha + cbpb_pkg::rnd_div_one(s6_prod_ff);
      end
   end

   // divider operands: num = 2*a*65535 + d, den = 2*d
   logic [2:0][15:0] s7_base, s7_layer;
   assign s7_base  = {s7_pix_ff.base_blue, s7_pix_ff.base_green, s7_pix_ff.base_red};
   assign s7_layer = {s7_pix_ff.layer_blue, s7_pix_ff.layer_green, s7_pix_ff.layer_red};

   function automatic logic [NB-1:0] div_num(input logic [15:0] a, input logic [15:0] d);
      logic [NB-1:0] aw;
      aw = {{(NB-16){1'b0}}, a};
      return (aw << 17) - (aw << 1) + {{(NB-16){1'b0}}, d};
   endfunction

   logic [15:0]      ratio_q;
   logic [2:0][15:0] burn_q;

   cbpb_div u_ratio_div (
      .clock (clock),
      .en    (en),
      .num   (div_num(s7_ca_ff, s7_na_ff)),
      .den   ({s7_na_ff, 1'b0}),
      .quo   (ratio_q)
   );

   for (genvar c = 0; c < 3; c++) begin : g_burn_div
      cbpb_div u_burn_div (
         .clock (clock),
         .en    (en),
         .num   (div_num(~s7_base[c], s7_layer[c])),
         .den   ({s7_layer[c], 1'b0}),
         .quo   (burn_q[c])
      );
   end

   // side data rides alongside the dividers
   side_type side_ff [0:DLAT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0].pix  <= s7_pix_ff;
         side_ff[0].copy <= (s7_ca_ff == cbpb_pkg::ZERO_FX) ||
                            (s7_na_ff == cbpb_pkg::ZERO_FX);
         for (int i = 1; i < DLAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   logic [2:0][15:0] d_base, d_layer;
   assign d_base  = {side_ff[DLAT-1].pix.base_blue, side_ff[DLAT-1].pix.base_green,
                     side_ff[DLAT-1].pix.base_red};
   assign d_layer = {side_ff[DLAT-1].pix.layer_blue, side_ff[DLAT-1].pix.layer_green,
                     side_ff[DLAT-1].pix.layer_red};

   // burn, mix products, sum, final rounding
   side_type         a_side_ff, m1_side_ff, m2_side_ff;
   logic [2:0][15:0] a_burn_ff;
   logic [15:0]      a_ratio_ff;
   logic [2:0][31:0] m1_pa_ff, m1_pb_ff, m2_sum_ff;
   logic [2:0][15:0] a_base, m2_base, out_col;
   cbpb_pkg::rsp_type rsp_ff;

   assign a_base  = {a_side_ff.pix.base_blue, a_side_ff.pix.base_green,
                     a_side_ff.pix.base_red};
   assign m2_base = {m2_side_ff.pix.base_blue, m2_side_ff.pix.base_green,
                     m2_side_ff.pix.base_red};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         out_col[c] = m2_side_ff.copy ? m2_base[c] : cbpb_pkg::rnd_div_one(m2_sum_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff  <= side_ff[DLAT-1];
         a_ratio_ff <= ratio_q;
         for (int c = 0; c < 3; c++) begin
            if (d_layer[c] == cbpb_pkg::ZERO_FX) begin
               a_burn_ff[c] <= (d_base[c] == cbpb_pkg::ONE_FX) ?
                               cbpb_pkg::ONE_FX : cbpb_pkg::ZERO_FX;
            end else begin
               a_burn_ff[c] <= cbpb_pkg::ONE_FX - burn_q[c];
            end
         end
         m1_side_ff <= a_side_ff;
         for (int c = 0; c < 3; c++) begin
            m1_pa_ff[c] <= a_burn_ff[c] * a_ratio_ff;
            m1_pb_ff[c] <= a_base[c] * {16'h0000, ~a_ratio_ff};
         end
         m2_side_ff <= m1_side_ff;
         for (int c = 0; c < 3; c++) begin
            m2_sum_ff[c] <= m1_pa_ff[c] + m1_pb_ff[c];
         end
         rsp_ff.out_red   <= out_col[0];
         rsp_ff.out_green <= out_col[1];
         rsp_ff.out_blue  <= out_col[2];
         rsp_ff.out_alpha <= m2_side_ff.pix.base_alpha;
         rsp_ff.out_last  <= m2_side_ff.pix.last_pixel;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pipeline not empty after reset");
   a_hold_freeze : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("valid bits moved while the output word was stalled");
   a_bubble_in : assert property (@(posedge clock) disable iff (reset)
      (en && !req_valid) |=> !vld_ff[0])
      else $error("first stage took a word that was not offered");
   a_take_in : assert property (@(posedge clock) disable iff (reset)
      (en && req_valid) |=> vld_ff[0])
      else $error("accepted word was dropped at the first stage");
`endif

endmodule

`default_nettype wire

// File: bench/color_burn_pixel_blend_tb.sv
// Self-checking bench for color_burn_pixel_blend: random and directed pixel words,
// a local color burn predictor and an in-order checker. Depends on cbpb_pkg and color_burn_pixel_blend.
`default_nettype none

module color_burn_pixel_blend_tb;

   localparam int PIPE_DEPTH = 29;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   cbpb_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   cbpb_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = cbpb_pkg::CSR_OPACITY;
   logic [15:0] csr_wdata = '0;

   color_burn_pixel_blend dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   cbpb_pkg::req_type pixel_queue[$];
   cbpb_pkg::rsp_type blend_expected[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_send = 1'b0;
   int idle_cycles = 0;

   // predictor copy of the registers
   logic [15:0] opacity_q = cbpb_pkg::ONE_FX;
   logic mask_en_q = 1'b0;

   function automatic logic [63:0] rdiv(input logic [63:0] num, input logic [63:0] den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      return rdiv(a * b, 64'd65535);
   endfunction

   function automatic logic [63:0] burn_of(input logic [63:0] b, input logic [63:0] l);
      logic [63:0] q;
      if (l == 0) return (b == 65535) ? 64'd65535 : 64'd0;
      q = rdiv((65535 - b) * 65535, l);
      return (q >= 65535) ? 64'd0 : 65535 - q;
   endfunction

   function automatic cbpb_pkg::rsp_type blend_pixel(input cbpb_pkg::req_type p);
      cbpb_pkg::rsp_type r;
      logic [63:0] ba, la, ca, na, ratio;
      logic [63:0] bs[3];
      logic [63:0] ls[3];
      logic [63:0] v;
      bs[0] = 64'(p.base_red); bs[1] = 64'(p.base_green); bs[2] = 64'(p.base_blue);
      ls[0] = 64'(p.layer_red); ls[1] = 64'(p.layer_green); ls[2] = 64'(p.layer_blue);
      ba = 64'(p.base_alpha);
      la = 64'(p.layer_alpha);
      ca = fx_mul(ba < la ? ba : la, 64'(opacity_q));
      if (mask_en_q) ca = fx_mul(ca, 64'(p.mask_value));
      na = ba + fx_mul(65535 - ba, ca);
      r.out_red = p.base_red;
      r.out_green = p.base_green;
      r.out_blue = p.base_blue;
      if (ca != 0 && na != 0) begin
         ratio = rdiv(ca * 65535, na);
         if (ratio > 65535) ratio = 65535;
         for (int i = 0; i < 3; i++) begin
            v = rdiv(burn_of(bs[i], ls[i]) * ratio + bs[i] * (65535 - ratio), 65535);
            if (i == 0) r.out_red = v[15:0];
            else if (i == 1) r.out_green = v[15:0];
            else r.out_blue = v[15:0];
         end
      end
      r.out_alpha = p.base_alpha;
      r.out_last = p.last_pixel;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   // driver: predict at acceptance so register writes line up
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            blend_expected.push_back(blend_pixel(req_data));
            void'(pixel_queue.pop_front());
         end
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (pixel_queue.size() > (req_valid && !req_stall ? 0 : 0) &&
                      !hold_send && pixel_queue.size() != 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pixel_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      cbpb_pkg::rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blend_expected.size() == 0) begin
            report_mismatch("unexpected word", rsp_data.out_red, 16'h0000);
         end else begin
            w = blend_expected.pop_front();
            if (rsp_data.out_red !== w.out_red) report_mismatch("red", rsp_data.out_red, w.out_red);
            if (rsp_data.out_green !== w.out_green)
               report_mismatch("green", rsp_data.out_green, w.out_green);
            if (rsp_data.out_blue !== w.out_blue)
               report_mismatch("blue", rsp_data.out_blue, w.out_blue);
            if (rsp_data.out_alpha !== w.out_alpha)
               report_mismatch("alpha", rsp_data.out_alpha, w.out_alpha);
            if (rsp_data.out_last !== w.out_last)
               report_mismatch("last", {15'd0, rsp_data.out_last}, {15'd0, w.out_last});
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [15:0] pick16();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(15));
         3: return 16'hFFFF - 16'($urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic cbpb_pkg::req_type random_pixel();
      cbpb_pkg::req_type p;
      p.base_red = pick16(); p.base_green = pick16(); p.base_blue = pick16();
      p.base_alpha = pick16();
      p.layer_red = pick16(); p.layer_green = pick16(); p.layer_blue = pick16();
      p.layer_alpha = pick16();
      p.mask_value = pick16();
      p.last_pixel = 1'($urandom_range(1));
      return p;
   endfunction

   task automatic drain();
      while (pixel_queue.size() != 0 || blend_expected.size() != 0 || req_valid)
         @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_reg(input cbpb_pkg::csr_index_type idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == cbpb_pkg::CSR_OPACITY) opacity_q = val;
      else mask_en_q = val[0];
   endtask

   task automatic send_phase(input int count);
      for (int i = 0; i < count; i++) pixel_queue.push_back(random_pixel());
   endtask

   initial begin
      cbpb_pkg::req_type p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero layer, zero alphas, burn clamp
      p = '0; pixel_queue.push_back(p);
      p = '1; pixel_queue.push_back(p);
      p = '1; p.layer_red = 16'h0000; p.layer_green = 16'h0000; p.base_green = 16'h1234;
      pixel_queue.push_back(p);
      p = '1; p.base_alpha = 16'h0000; p.layer_alpha = 16'h0000; pixel_queue.push_back(p);
      p = '1; p.base_red = 16'h0000; p.layer_red = 16'h0001; p.base_blue = 16'h8000;
      p.layer_blue = 16'h8000; p.base_alpha = 16'h0000; p.last_pixel = 1'b0;
      pixel_queue.push_back(p);
      p = '0; p.base_alpha = 16'hFFFF; p.layer_alpha = 16'h0001; p.base_red = 16'hFFFF;
      pixel_queue.push_back(p);
      send_phase(10);
      drain();
      write_reg(cbpb_pkg::CSR_OPACITY, 16'h0000);
      send_phase(8);
      drain();
      write_reg(cbpb_pkg::CSR_OPACITY, 16'h0001);
      write_reg(cbpb_pkg::CSR_MASK_ENABLE, 16'h0001);
      p = '1; p.mask_value = 16'h0000; pixel_queue.push_back(p);
      p = '1; p.base_alpha = 16'h0001; p.mask_value = 16'hFFFF; pixel_queue.push_back(p);
      drain();

      send_idle_pct = 35; recv_idle_pct = 63;
      write_reg(cbpb_pkg::CSR_OPACITY, 16'hFFFF);
      send_phase(300);
      drain();
      write_reg(cbpb_pkg::CSR_OPACITY, 16'($urandom));
      send_phase(300);
      while (pixel_queue.size() > 150) @(posedge clock);
      // pause until every word in flight has come back
      hold_send = 1'b1;
      @(posedge clock);
      while (blend_expected.size() != 0 || req_valid) @(posedge clock);
      hold_send = 1'b0;
      drain();

      send_idle_pct = 63; recv_idle_pct = 35;
      write_reg(cbpb_pkg::CSR_MASK_ENABLE, 16'h0000);
      send_phase(300);
      drain();
      write_reg(cbpb_pkg::CSR_OPACITY, 16'h0000);
      send_phase(100);
      drain();

      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(cbpb_pkg::CSR_OPACITY, 16'hFFFF);
      write_reg(cbpb_pkg::CSR_MASK_ENABLE, 16'h0001);
      send_phase(400);
      drain();
      write_reg(cbpb_pkg::CSR_OPACITY, 16'($urandom));
      write_reg(cbpb_pkg::CSR_MASK_ENABLE, 16'h0000);
      send_phase(450);
      drain();

      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

`default_nettype wire
